### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the circular deque.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CDQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("deque assertion failed");
`define CDQ_ASSERT_IMPLY(lbl, clk, rst_n, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
		else $error("deque implication failed");
`else
`define CDQ_ASSERT(lbl, clk, rst_n, prop)
`define CDQ_ASSERT_IMPLY(lbl, clk, rst_n, pre, con)
`endif
`endif

### rtl/cdq_pkg.sv
// Types and constants of the circular deque: operation and error codes,
// controller states and the command bundle. No dependencies.
package cdq_pkg;

	localparam int MODE_W = 3;
	localparam int DATA_W = 32;
	localparam int OCC_W  = 4;
	localparam int ERR_W  = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

	// Word reported at both ends when the deque is empty.
	localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_READ = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;   // capture the incoming request
		logic exec;   // apply the operation to pointers, count and memory
		logic rd_en;  // fetch the front and back words
	} cmd_t;

endpackage

### rtl/cdq_ram.sv
// Generic simple RAM: one write port and two read ports with registered data.
// No dependencies.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### rtl/cdq_ctrl.sv
// Controller of the circular deque: sequences accept, update, read and respond.
// Depends on cdq_pkg.
module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output cdq_pkg::cmd_t cmd
);
	import cdq_pkg::*;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_EXEC;
			end
			ST_EXEC: state_n = ST_READ;
			ST_READ: state_n = ST_RESP;
			ST_RESP: begin
				if (!out_stall) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_RESP);

	always_comb begin
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		cmd.exec  = (state_q == ST_EXEC);
		cmd.rd_en = (state_q == ST_READ);
	end

endmodule

### rtl/cdq_datapath.sv
// Datapath of the circular deque: request registers, pointers, count, error
// and the entry memory. Depends on cdq_pkg, cdq_ram and assert_macros.svh.
`include "assert_macros.svh"
module cdq_datapath #(
	parameter int DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdq_pkg::cmd_t                       cmd,
	input  logic [cdq_pkg::MODE_W-1:0]          mode,
	input  logic signed [cdq_pkg::DATA_W-1:0]   data,
	output logic signed [cdq_pkg::DATA_W-1:0]   front_value,
	output logic signed [cdq_pkg::DATA_W-1:0]   back_value,
	output logic [cdq_pkg::OCC_W-1:0]           occupancy,
	output logic                                is_empty,
	output logic                                is_full,
	output logic [cdq_pkg::ERR_W-1:0]           error
);
	import cdq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] data_q;
	logic [PW-1:0]     front_q, back_q, front_n, back_n, waddr;
	logic [CW-1:0]     count_q, count_n;
	logic [ERR_W-1:0]  err_q, err_n;
	logic              we;
	logic [DATA_W-1:0] rd_front, rd_back;
	logic              cur_empty, cur_full;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? LAST : p - 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			data_q <= data;
		end
	end

	assign cur_empty = (count_q == '0);
	assign cur_full  = (count_q == FULLC);

	always_comb begin
		front_n = front_q;
		back_n  = back_q;
		count_n = count_q;
		err_n   = ERR_NONE;
		we      = 1'b0;
		waddr   = '0;
		if (mode_q == MODE_PUSH_FRONT || mode_q == MODE_PUSH_BACK) begin
			if (cur_full) begin
				err_n = ERR_OVERFLOW;
			end else begin
				we      = 1'b1;
				count_n = count_q + 1'b1;
				if (cur_empty) begin
					front_n = '0;
					back_n  = '0;
					waddr   = '0;
				end else if (mode_q == MODE_PUSH_FRONT) begin
					front_n = ptr_dec(front_q);
					waddr   = front_n;
				end else begin
					back_n = ptr_inc(back_q);
					waddr  = back_n;
				end
			end
		end else if (mode_q == MODE_POP_FRONT || mode_q == MODE_POP_BACK) begin
			if (cur_empty) begin
				err_n = ERR_UNDERFLOW;
			end else begin
				count_n = count_q - 1'b1;
				if (count_q == CW'(1)) begin
					front_n = '0;
					back_n  = '0;
				end else if (mode_q == MODE_POP_FRONT) begin
					front_n = ptr_inc(front_q);
				end else begin
					back_n = ptr_dec(back_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			err_q   <= ERR_NONE;
		end else if (cmd.exec) begin
			front_q <= front_n;
			back_q  <= back_n;
			count_q <= count_n;
			err_q   <= err_n;
		end
	end

	cdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (cmd.exec && we),
		.waddr  (waddr),
		.wdata  (data_q),
		.re     (cmd.rd_en),
		.raddr_a(front_q),
		.raddr_b(back_q),
		.rdata_a(rd_front),
		.rdata_b(rd_back)
	);

	assign front_value = cur_empty ? INT_MIN : $signed(rd_front);
	assign back_value  = cur_empty ? INT_MIN : $signed(rd_back);
	assign occupancy   = OCC_W'(count_q);
	assign is_empty    = cur_empty;
	assign is_full     = cur_full;
	assign error       = err_q;

	`CDQ_ASSERT(a_count_bound, clk, arst_n, count_q <= FULLC)
	`CDQ_ASSERT_IMPLY(a_empty_ptrs, clk, arst_n, cur_empty, front_q == '0 && back_q == '0)
	`CDQ_ASSERT_IMPLY(a_write_room, clk, arst_n, cmd.exec && we, !cur_full)
	`CDQ_ASSERT(a_err_hold, clk, arst_n, (cmd.exec && err_n != ERR_NONE) |=> $stable(count_q))

endmodule

### rtl/circular_deque_unit.sv
// Top level of the circular deque: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
// Usage: a request on the input channel (in_valid, in_stall, mode, data) pushes
// a word at the front or back, pops one from either end, or only reads. Every
// request yields exactly one response on the output channel (out_valid,
// out_stall) that describes the deque after the operation: front and back
// words, occupancy, empty and full flags, and an error code for a refused push
// (overflow) or pop (underflow). A refused request leaves the state unchanged.
// Timing: one request is handled at a time. After acceptance the controller
// updates pointers, count and the entry memory (ST_EXEC), performs the
// registered memory read of both ends (ST_READ) and then presents the
// response (ST_RESP), where out_valid is high. A request passes through the
// idle state that takes it, the update, the memory read and the response
// state, which is left once out_stall is low.
// While out_stall is high the response is held unchanged and in_stall stays
// high, so no new request is taken.
// Reset clears pointers, count and the controller; the entry memory is not
// cleared, as empty ends are reported as the most negative word.
module circular_deque_unit #(
	parameter int DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cdq_pkg::MODE_W-1:0]        mode,
	input  logic signed [cdq_pkg::DATA_W-1:0] data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [cdq_pkg::DATA_W-1:0] front_value,
	output logic signed [cdq_pkg::DATA_W-1:0] back_value,
	output logic [cdq_pkg::OCC_W-1:0]         occupancy,
	output logic                              is_empty,
	output logic                              is_full,
	output logic [cdq_pkg::ERR_W-1:0]         error
);
	import cdq_pkg::*;

	// Commands from the sequencer to the datapath.
	cmd_t cmd;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	// The datapath holds the response fields stable from the read until the
	// next request is accepted, which covers any stall on the output side.
	cdq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.data       (data),
		.front_value(front_value),
		.back_value (back_value),
		.occupancy  (occupancy),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.error      (error)
	);

endmodule
